/* sv/dsvm_pkg.sv */
package dsvm_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 9;
	localparam int GAIN_UNITY = 256;
	localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
	localparam int FRAC_SHIFT = 8;
	localparam int MASK_W     = 8;

	typedef enum logic [2:0] {
		OP_WRITE_WORD = 3'd0,
		OP_SET_LENGTH = 3'd1,
		OP_SET_GAIN   = 3'd2,
		OP_TRIGGER    = 3'd3,
		OP_TICK       = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CFG,
		ST_VEVAL,
		ST_LMUL,
		ST_LACC,
		ST_RACC,
		ST_FINISH
	} state_t;

	// Multiply-accumulate controls from the sequencer to the mixer.
	typedef struct packed {
		logic clear;
		logic mul_en;
		logic acc_left;
		logic acc_right;
	} mac_ctl_t;

endpackage

/* sv/dsvm_ram.sv */
module dsvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/dsvm_mix.sv */
module dsvm_mix #(
	parameter int VOICE_COUNT = 8
) (
	input  logic                                     clk,
	input  dsvm_pkg::mac_ctl_t                       ctl,
	input  logic signed [dsvm_pkg::SAMPLE_W-1:0]     word,
	input  logic        [dsvm_pkg::GAIN_W-1:0]       gain,
	output logic signed [dsvm_pkg::SAMPLE_W-1:0]     left_sat,
	output logic signed [dsvm_pkg::SAMPLE_W-1:0]     right_sat
);

	localparam int ACC_W = dsvm_pkg::PROD_W + $clog2(VOICE_COUNT) + 1;
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

	logic signed [dsvm_pkg::PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]            lacc_q;
	logic signed [ACC_W-1:0]            racc_q;

	function automatic logic signed [dsvm_pkg::SAMPLE_W-1:0] sat16(
		input logic signed [ACC_W-1:0] a
	);
		logic signed [ACC_W-1:0] sh;
		sh = a >>> dsvm_pkg::FRAC_SHIFT;
		if (sh > SAT_HI) begin
			return 16'sh7fff;
		end else if (sh < SAT_LO) begin
			return 16'sh8000;
		end else begin
			return sh[dsvm_pkg::SAMPLE_W-1:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= word * $signed({1'b0, gain});
		end
		if (ctl.clear) begin
			lacc_q <= '0;
			racc_q <= '0;
		end else begin
			if (ctl.acc_left) begin
				lacc_q <= lacc_q + ACC_W'(prod_s1);
			end
			if (ctl.acc_right) begin
				racc_q <= racc_q + ACC_W'(prod_s1);
			end
		end
	end

	assign left_sat  = sat16(lacc_q);
	assign right_sat = sat16(racc_q);

endmodule

/* sv/drum_sample_voice_mixer_core.sv */
// A word write is done as it is accepted; a length, gain or trigger item passes through the
// configuration step. A tick walks the voices in order: a silent voice is retired in its evaluate
// step, a voice that plays one word goes through left fetch, multiply and accumulate steps, and
// one that plays two adds a right accumulate step; a finish step then presents the frame, later
// while the previous frame still waits, and the next item is taken after that. One item is in work at a time.
// Reset clears control only: voice state reads as idle, length zero, unity gain via valid bits.
module drum_sample_voice_mixer_core #(
	parameter int VOICE_COUNT     = 8,
	parameter int WORDS_PER_VOICE = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         op,
	input  logic [2:0]         voice,
	input  logic [11:0]        word_index,
	input  logic signed [15:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] left_out,
	output logic signed [15:0] right_out,
	output logic [7:0]         active_voices
);

	localparam int VIDX_W   = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int LEN_W    = $clog2(WORDS_PER_VOICE + 1);
	localparam int SA_DEPTH = VOICE_COUNT * WORDS_PER_VOICE;
	localparam int SA_W     = $clog2(SA_DEPTH);
	localparam int GAIN_W   = dsvm_pkg::GAIN_W;
	localparam int VS_W     = 1 + GAIN_W + 2 * LEN_W;
	localparam logic [dsvm_pkg::MASK_W-1:0] MASK_LIVE = (VOICE_COUNT >= dsvm_pkg::MASK_W) ?
		'1 : dsvm_pkg::MASK_W'((1 << VOICE_COUNT) - 1);

	// One voice entry in the voice state memory.
	typedef struct packed {
		logic              active;
		logic [GAIN_W-1:0] gain;
		logic [LEN_W-1:0]  len;
		logic [LEN_W-1:0]  pos;
	} vstate_t;

	localparam vstate_t ENT_RESET = '{
		active: 1'b0,
		gain:   GAIN_W'(dsvm_pkg::GAIN_UNITY),
		len:    '0,
		pos:    '0
	};

	// Sequencer state
	dsvm_pkg::state_t st_q, st_d;
	logic [VIDX_W-1:0]      vidx_q;
	logic [VOICE_COUNT-1:0] vld_q;
	logic                   rd_vld_s1;
	logic                   out_valid_q;

	// Item and voice payload
	dsvm_pkg::op_t      op_q;
	logic [VIDX_W-1:0]  voice_idx_q;
	logic signed [15:0] value_q;
	logic [SA_W-1:0]    base_q;
	logic [LEN_W-1:0]   pos_q;
	logic [LEN_W-1:0]   len_q;
	logic [GAIN_W-1:0]  gain_q;
	logic               right_q;
	logic [dsvm_pkg::MASK_W-1:0] mask_q;
	logic signed [15:0] left_q;
	logic signed [15:0] right_q_out;
	logic [dsvm_pkg::MASK_W-1:0] active_q;

	// Memory ports
	logic              st_we;
	logic [VIDX_W-1:0] st_waddr;
	vstate_t           st_wdata;
	logic [VIDX_W-1:0] st_raddr;
	logic [VS_W-1:0]   st_rdata;
	logic              sa_we;
	logic [SA_W-1:0]   sa_waddr;
	logic [SA_W-1:0]   sa_raddr;
	logic [15:0]       sa_rdata;

	// Strobes
	logic               in_acc;
	logic               voice_ok;
	logic               widx_ok;
	logic               cfg_start;
	logic               tick_start;
	logic               vs_load;
	logic               adv;
	logic               mask_set;
	logic               out_load;
	vstate_t            ent;
	logic [LEN_W-1:0]   npos;
	logic [LEN_W:0]     ent_pos_inc;
	dsvm_pkg::mac_ctl_t mac_ctl;
	logic signed [15:0] mix_left;
	logic signed [15:0] mix_right;

	assign in_ready = (st_q == dsvm_pkg::ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign voice_ok = int'(voice) < VOICE_COUNT;
	assign widx_ok  = int'(word_index) < WORDS_PER_VOICE;

	// A never-written voice entry reads as its reset value.
	assign ent         = rd_vld_s1 ? vstate_t'(st_rdata) : ENT_RESET;
	assign ent_pos_inc = {1'b0, ent.pos} + (LEN_W + 1)'(1);

	assign sa_waddr = SA_W'(int'(voice) * WORDS_PER_VOICE + int'(word_index));

	always_comb begin
		st_d       = st_q;
		st_we      = 1'b0;
		st_waddr   = vidx_q;
		st_wdata   = ent;
		st_raddr   = vidx_q;
		sa_we      = 1'b0;
		sa_raddr   = base_q;
		cfg_start  = 1'b0;
		tick_start = 1'b0;
		vs_load    = 1'b0;
		adv        = 1'b0;
		mask_set   = 1'b0;
		out_load   = 1'b0;
		npos       = pos_q;
		mac_ctl    = '0;

		case (st_q)
			dsvm_pkg::ST_IDLE: begin
				if (in_acc) begin
					case (op)
						dsvm_pkg::OP_WRITE_WORD: begin
							sa_we = voice_ok && widx_ok;
						end
						dsvm_pkg::OP_SET_LENGTH, dsvm_pkg::OP_SET_GAIN,
						dsvm_pkg::OP_TRIGGER: begin
							// Fetch the voice entry, then rewrite it.
							if (voice_ok) begin
								cfg_start = 1'b1;
								st_raddr  = VIDX_W'(voice);
								st_d      = dsvm_pkg::ST_CFG;
							end
						end
						dsvm_pkg::OP_TICK: begin
							tick_start    = 1'b1;
							mac_ctl.clear = 1'b1;
							st_raddr      = '0;
							st_d          = dsvm_pkg::ST_VEVAL;
						end
						default: begin
							// Drop unknown ops.
						end
					endcase
				end
			end

			dsvm_pkg::ST_CFG: begin
				st_we    = 1'b1;
				st_waddr = voice_idx_q;
				case (op_q)
					dsvm_pkg::OP_SET_LENGTH: begin
						if (value_q < 0) begin
							st_wdata.len = '0;
						end else if (int'(value_q) > WORDS_PER_VOICE) begin
							st_wdata.len = LEN_W'(WORDS_PER_VOICE);
						end else begin
							st_wdata.len = LEN_W'(value_q);
						end
					end
					dsvm_pkg::OP_SET_GAIN: begin
						if (value_q < 0) begin
							st_wdata.gain = '0;
						end else if (int'(value_q) > dsvm_pkg::GAIN_UNITY) begin
							st_wdata.gain = GAIN_W'(dsvm_pkg::GAIN_UNITY);
						end else begin
							st_wdata.gain = GAIN_W'(value_q);
						end
					end
					dsvm_pkg::OP_TRIGGER: begin
						st_wdata.pos    = '0;
						st_wdata.active = 1'b1;
					end
					default: begin
					end
				endcase
				st_d = dsvm_pkg::ST_IDLE;
			end

			dsvm_pkg::ST_VEVAL: begin
				if (ent.active && (ent.pos < ent.len)) begin
					// Voice plays: fetch the left word.
					vs_load  = 1'b1;
					sa_raddr = base_q + SA_W'(ent.pos);
					st_d     = dsvm_pkg::ST_LMUL;
				end else begin
					// Silent or finished voice: retire it and move on.
					st_we           = 1'b1;
					st_wdata.active = 1'b0;
					adv             = 1'b1;
				end
			end

			dsvm_pkg::ST_LMUL: begin
				mac_ctl.mul_en = 1'b1;
				sa_raddr       = base_q + SA_W'(pos_q) + SA_W'(1);
				st_d           = dsvm_pkg::ST_LACC;
			end

			dsvm_pkg::ST_LACC: begin
				mac_ctl.acc_left = 1'b1;
				mac_ctl.mul_en   = 1'b1;
				if (right_q) begin
					st_d = dsvm_pkg::ST_RACC;
				end else begin
					npos            = pos_q + LEN_W'(1);
					st_we           = 1'b1;
					st_wdata        = '{active: npos < len_q, gain: gain_q, len: len_q, pos: npos};
					mask_set        = st_wdata.active;
					adv             = 1'b1;
				end
			end

			dsvm_pkg::ST_RACC: begin
				mac_ctl.acc_right = 1'b1;
				npos              = pos_q + LEN_W'(2);
				st_we             = 1'b1;
				st_wdata          = '{active: npos < len_q, gain: gain_q, len: len_q, pos: npos};
				mask_set          = st_wdata.active;
				adv               = 1'b1;
			end

			dsvm_pkg::ST_FINISH: begin
				// Hold the frame until the output register frees up.
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					st_d     = dsvm_pkg::ST_IDLE;
				end
			end

			default: begin
				st_d = dsvm_pkg::ST_IDLE;
			end
		endcase

		// Step to the next voice, or close the frame after the last one.
		if (adv) begin
			if (vidx_q == VIDX_W'(VOICE_COUNT - 1)) begin
				st_d = dsvm_pkg::ST_FINISH;
			end else begin
				st_raddr = vidx_q + VIDX_W'(1);
				st_d     = dsvm_pkg::ST_VEVAL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= dsvm_pkg::ST_IDLE;
			vidx_q      <= '0;
			vld_q       <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q      <= st_d;
			rd_vld_s1 <= vld_q[st_raddr];
			if (st_we) begin
				vld_q[st_waddr] <= 1'b1;
			end
			if (tick_start) begin
				vidx_q <= '0;
			end else if (adv && (st_d == dsvm_pkg::ST_VEVAL)) begin
				vidx_q <= vidx_q + VIDX_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cfg_start) begin
			op_q        <= dsvm_pkg::op_t'(op);
			voice_idx_q <= VIDX_W'(voice);
			value_q     <= value;
		end
		if (tick_start) begin
			base_q <= '0;
			mask_q <= '0;
		end else begin
			if (adv && (st_d == dsvm_pkg::ST_VEVAL)) begin
				base_q <= base_q + SA_W'(WORDS_PER_VOICE);
			end
			for (int i = 0; i < dsvm_pkg::MASK_W; i++) begin
				if (mask_set && (i < VOICE_COUNT) && (int'(vidx_q) == i)) begin
					mask_q[i] <= 1'b1;
				end
			end
		end
		if (vs_load) begin
			pos_q   <= ent.pos;
			len_q   <= ent.len;
			gain_q  <= ent.gain;
			right_q <= ent_pos_inc < {1'b0, ent.len};
		end
		if (out_load) begin
			left_q      <= mix_left;
			right_q_out <= mix_right;
			active_q    <= mask_q;
		end
	end

	dsvm_ram #(
		.WIDTH(VS_W),
		.DEPTH(VOICE_COUNT)
	) u_voice_ram (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	dsvm_ram #(
		.WIDTH(dsvm_pkg::SAMPLE_W),
		.DEPTH(SA_DEPTH)
	) u_sample_ram (
		.clk  (clk),
		.we   (sa_we),
		.waddr(sa_waddr),
		.wdata(value),
		.raddr(sa_raddr),
		.rdata(sa_rdata)
	);

	dsvm_mix #(
		.VOICE_COUNT(VOICE_COUNT)
	) u_mix (
		.clk      (clk),
		.ctl      (mac_ctl),
		.word     ($signed(sa_rdata)),
		.gain     (gain_q),
		.left_sat (mix_left),
		.right_sat(mix_right)
	);

	assign out_valid     = out_valid_q;
	assign left_out      = left_q;
	assign right_out     = right_q_out;
	assign active_voices = active_q;

	// A frame appears only out of the finish step.
	a_frame_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(st_q) == dsvm_pkg::ST_FINISH))
		else $error("frame raised outside the finish step");

	// A playing voice never fetches its left word at or past its length.
	a_fetch_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == dsvm_pkg::ST_LMUL) |-> (pos_q < len_q))
		else $error("sample fetch beyond voice length");

	// Only existing voices can be reported active.
	a_mask_live: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((active_voices & ~MASK_LIVE) == '0))
		else $error("active bit set for a missing voice");

endmodule

/* tb/sv/tb_drum_sample_voice_mixer_core.sv */
module tb_drum_sample_voice_mixer_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VOICES       = 8;
	localparam int WORDS        = 4096;
	localparam int ITEM_TARGET  = 1650;
	localparam int CYCLE_LIMIT  = 800000;
	localparam int DRAIN_CYCLES = 100;
	localparam int GAIN_MAX     = dsvm_pkg::GAIN_UNITY;
	// Op codes with no meaning to the block; it drops them without a frame.
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	typedef struct {
		logic [2:0]         op;
		logic [2:0]         vsel;
		logic [11:0]        widx;
		logic signed [15:0] val;
	} item_t;

	typedef struct {
		logic signed [15:0] l_smp;
		logic signed [15:0] r_smp;
		logic [7:0]         act_mask;
	} frame_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         op;
	logic [2:0]         voice;
	logic [11:0]        word_index;
	logic signed [15:0] value;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;
	logic [7:0]         active_voices;

	drum_sample_voice_mixer_core #(
		.VOICE_COUNT(VOICES),
		.WORDS_PER_VOICE(WORDS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.voice(voice),
		.word_index(word_index),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_out(left_out),
		.right_out(right_out),
		.active_voices(active_voices)
	);

	// Items waiting for the driver, and frames the mixer still owes us.
	item_t  pending_q[$];
	frame_t frame_q[$];

	// Mirror of the voice bank, updated as each item is accepted.
	logic signed [15:0] mix_store [0:VOICES*WORDS-1];
	int                 mix_len   [VOICES];
	int                 mix_pos   [VOICES];
	int                 mix_gain  [VOICES];
	bit                 mix_act   [VOICES];

	// Stimulus-side shadow: where each voice will be when an item reaches the
	// block, and which store words hold data. Used to keep every tick from
	// reading a word that was never written.
	bit plan_written [0:VOICES*WORDS-1];
	int plan_len [VOICES];
	int plan_pos [VOICES];
	bit plan_act [VOICES];

	int items_planned;
	int items_total;
	int items_taken;
	int frames_checked;
	int sat_hits;
	int triggers_seen;
	int error_count;
	int cycle_count;
	bit in_took;
	item_t drv_item;

	// Count a failure and print one line about it.
	task automatic report_mismatch(input string what, input int got, input int want);
		error_count++;
		$display("MISMATCH at cycle %0d, %s: got %0d, expected %0d", cycle_count, what, got,
			want);
	endtask

	// Floor divide by unity gain, then clamp into Q1.15.
	function automatic logic signed [15:0] to_q15(input longint sum);
		longint q;
		q = sum >>> dsvm_pkg::FRAC_SHIFT;
		if (q > 32767) begin
			sat_hits++;
			q = 32767;
		end else if (q < -32768) begin
			sat_hits++;
			q = -32768;
		end
		return q[15:0];
	endfunction

	// Apply one accepted item to the mirror; a tick yields one expected frame.
	task automatic mix_accept(input item_t it);
		longint l_sum;
		longint r_sum;
		frame_t fr;
		int     v;
		int     n;
		l_sum = 0;
		r_sum = 0;
		n = it.val;
		case (it.op)
			dsvm_pkg::OP_WRITE_WORD: mix_store[{it.vsel, it.widx}] = it.val;
			dsvm_pkg::OP_SET_LENGTH: mix_len[it.vsel] = (n < 0) ? 0 : (n > WORDS) ? WORDS : n;
			dsvm_pkg::OP_SET_GAIN:
				mix_gain[it.vsel] = (n < 0) ? 0 : (n > GAIN_MAX) ? GAIN_MAX : n;
			dsvm_pkg::OP_TRIGGER: begin
				mix_pos[it.vsel] = 0;
				mix_act[it.vsel] = 1'b1;
				triggers_seen++;
			end
			dsvm_pkg::OP_TICK: begin
				for (v = 0; v < VOICES; v++) begin
					if (mix_act[v] && mix_pos[v] < mix_len[v]) begin
						l_sum += longint'(mix_store[v * WORDS + mix_pos[v]]) * mix_gain[v];
						mix_pos[v]++;
						if (mix_pos[v] < mix_len[v]) begin
							r_sum += longint'(mix_store[v * WORDS + mix_pos[v]]) * mix_gain[v];
							mix_pos[v]++;
						end
					end
				end
				fr.act_mask = '0;
				for (v = 0; v < VOICES; v++) begin
					if (mix_act[v] && mix_pos[v] >= mix_len[v])
						mix_act[v] = 1'b0;
					fr.act_mask[v] = mix_act[v];
				end
				fr.l_smp = to_q15(l_sum);
				fr.r_smp = to_q15(r_sum);
				frame_q = {frame_q, fr};
			end
			default: ;
		endcase
	endtask

	// Queue one item and advance the stimulus shadow the same way.
	task automatic queue_item(input logic [2:0] o, input logic [2:0] vs, input logic [11:0] wi,
			input logic signed [15:0] vl);
		item_t it;
		int    v;
		int    n;
		it.op = o;
		it.vsel = vs;
		it.widx = wi;
		it.val = vl;
		pending_q = {pending_q, it};
		items_planned++;
		n = vl;
		case (o)
			dsvm_pkg::OP_WRITE_WORD: plan_written[{vs, wi}] = 1'b1;
			dsvm_pkg::OP_SET_LENGTH: plan_len[vs] = (n < 0) ? 0 : (n > WORDS) ? WORDS : n;
			dsvm_pkg::OP_TRIGGER: begin
				plan_pos[vs] = 0;
				plan_act[vs] = 1'b1;
			end
			dsvm_pkg::OP_TICK: begin
				for (v = 0; v < VOICES; v++) begin
					if (plan_act[v] && plan_pos[v] < plan_len[v])
						plan_pos[v] += (plan_pos[v] + 1 < plan_len[v]) ? 2 : 1;
					if (plan_act[v] && plan_pos[v] >= plan_len[v])
						plan_act[v] = 1'b0;
				end
			end
			default: ;
		endcase
	endtask

	// Sample words lean toward full scale so the mix saturates now and then.
	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(3))
			0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Fill any word this tick will read that still holds nothing, then tick.
	task automatic queue_tick();
		int v;
		int p;
		for (v = 0; v < VOICES; v++) begin
			if (plan_act[v]) begin
				for (p = plan_pos[v]; p < plan_len[v] && p < plan_pos[v] + 2; p++) begin
					if (!plan_written[v * WORDS + p])
						queue_item(dsvm_pkg::OP_WRITE_WORD, 3'(v), 12'(p), pick_sample());
				end
			end
		end
		queue_item(dsvm_pkg::OP_TICK, 3'($urandom), 12'($urandom), 16'($urandom));
	endtask

	task automatic queue_random_item();
		int r;
		int pick;
		logic [2:0] vs;
		logic signed [15:0] vl;
		r = $urandom_range(99);
		vs = 3'($urandom);
		pick = $urandom_range(9);
		if (r < 8) begin
			queue_item(dsvm_pkg::OP_WRITE_WORD, vs, 12'($urandom), pick_sample());
		end else if (r < 18) begin
			// Mostly short sounds; a few wild or boundary lengths.
			if (pick < 8)
				vl = 16'($urandom_range(48));
			else if (pick == 8)
				vl = 16'($urandom);
			else
				vl = 16'(WORDS - 1 + $urandom_range(2));
			queue_item(dsvm_pkg::OP_SET_LENGTH, vs, 12'($urandom), vl);
		end else if (r < 26) begin
			vl = (pick < 7) ? 16'($urandom_range(GAIN_MAX)) : 16'($urandom);
			queue_item(dsvm_pkg::OP_SET_GAIN, vs, 12'($urandom), vl);
		end else if (r < 40) begin
			queue_item(dsvm_pkg::OP_TRIGGER, vs, 12'($urandom), 16'($urandom));
		end else if (r < 43) begin
			queue_item(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), vs, 12'($urandom),
				16'($urandom));
		end else begin
			queue_tick();
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = dsvm_pkg::OP_WRITE_WORD;
		voice = '0;
		word_index = '0;
		value = '0;
		out_ready = 1'b0;
		in_took = 1'b0;
		for (int v = 0; v < VOICES; v++) begin
			mix_len[v] = 0;
			mix_pos[v] = 0;
			mix_gain[v] = GAIN_MAX;
			mix_act[v] = 1'b0;
			plan_len[v] = 0;
			plan_pos[v] = 0;
			plan_act[v] = 1'b0;
		end
	end

	always #4 clk = ~clk;

	// Build the whole stimulus up front, then release reset and wait for the drain.
	initial begin
		// Full-scale words, the top word address, and an odd-length sound whose
		// last word plays with a silent right side.
		queue_item(dsvm_pkg::OP_WRITE_WORD, 3'd0, 12'd0, 16'sh7fff);
		queue_item(dsvm_pkg::OP_WRITE_WORD, 3'd0, 12'd1, 16'sh8000);
		queue_item(dsvm_pkg::OP_WRITE_WORD, 3'd0, 12'd2, 16'sh0001);
		queue_item(dsvm_pkg::OP_WRITE_WORD, 3'd0, 12'hfff, 16'sh8000);
		queue_item(dsvm_pkg::OP_SET_LENGTH, 3'd0, 12'd0, 16'sd3);
		// Gain clamps at both ends, plus zero gain.
		queue_item(dsvm_pkg::OP_SET_GAIN, 3'd1, 12'd0, -16'sd1);
		queue_item(dsvm_pkg::OP_SET_GAIN, 3'd2, 12'd0, 16'sd300);
		queue_item(dsvm_pkg::OP_SET_GAIN, 3'd3, 12'd0, 16'sd0);
		queue_item(dsvm_pkg::OP_SET_GAIN, 3'd0, 12'd0, 16'sh7fff);
		// Negative length clamps to zero; trigger that silent voice.
		queue_item(dsvm_pkg::OP_SET_LENGTH, 3'd1, 12'd0, -16'sd100);
		queue_item(dsvm_pkg::OP_TRIGGER, 3'd1, 12'd0, 16'sd0);
		// Oversize length clamps to the full store.
		queue_item(dsvm_pkg::OP_SET_LENGTH, 3'd7, 12'd0, 16'sh7fff);
		queue_item(dsvm_pkg::OP_TRIGGER, 3'd7, 12'd0, 16'sd0);
		queue_item(dsvm_pkg::OP_TRIGGER, 3'd0, 12'd0, 16'sd0);
		queue_item(OP_UNUSED_LO, 3'd0, 12'd0, 16'sd0);
		queue_item(OP_UNUSED_HI, 3'd7, 12'hfff, -16'sd1);
		queue_tick();
		queue_tick();
		queue_tick();
		// Shrink an active voice below its position: it drops out silently.
		queue_item(dsvm_pkg::OP_SET_LENGTH, 3'd7, 12'd0, 16'sd1);
		queue_tick();
		// Tick with nothing playing.
		queue_tick();

		while (items_planned < ITEM_TARGET)
			queue_random_item();
		items_total = pending_q.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Hold until every item is in and every frame is out, then watch for strays.
		while (pending_q.size() != 0 || in_valid || frame_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (frame_q.size() != 0)
			report_mismatch("frames never produced", frame_q.size(), 0);
		$display("Run covered %0d items (%0d triggers) and %0d mixed frames,", items_taken,
			triggers_seen, frames_checked);
		$display("with %0d saturated channel sums, across three handshake pacing phases.",
			sat_hits);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Drop the run if it hangs.
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("Timeout after %0d cycles", cycle_count);
		$display("CHECKS FAILED");
		$finish;
	end

	// Sample both handshakes on the rising edge: accept items into the mirror,
	// and compare delivered frames against the oldest expectation.
	always @(posedge clk) begin
		cycle_count++;
		if (arst_n && in_valid && in_ready) begin
			drv_item.op = op;
			drv_item.vsel = voice;
			drv_item.widx = word_index;
			drv_item.val = value;
			mix_accept(drv_item);
			items_taken++;
			in_took = 1'b1;
		end
		if (arst_n && out_valid && out_ready) begin
			if (frame_q.size() == 0) begin
				report_mismatch("frame with no tick pending, left_out", left_out, 0);
			end else begin
				frame_t want;
				want = frame_q.pop_front();
				frames_checked++;
				if (left_out !== want.l_smp)
					report_mismatch("left_out", left_out, want.l_smp);
				if (right_out !== want.r_smp)
					report_mismatch("right_out", right_out, want.r_smp);
				if (active_voices !== want.act_mask)
					report_mismatch("active_voices", active_voices, want.act_mask);
			end
		end
	end

	// Pacing by phase: sender gaps 34% with receiver stalls 69%, then swapped,
	// then a final third running flat out on both sides.
	function automatic int send_gap_pct();
		int third;
		third = (items_total == 0) ? 0 : (items_taken * 3) / items_total;
		return (third == 0) ? 34 : (third == 1) ? 69 : 0;
	endfunction

	function automatic int recv_stall_pct();
		int third;
		third = (items_total == 0) ? 0 : (items_taken * 3) / items_total;
		return (third == 0) ? 69 : (third == 1) ? 34 : 0;
	endfunction

	// Drive on the falling edge. Hold the current item until it is taken,
	// then either present the next one or leave the input idle.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_took) begin
				in_took = 1'b0;
				if (pending_q.size() != 0 && $urandom_range(99) >= send_gap_pct()) begin
					item_t nxt;
					nxt = pending_q.pop_front();
					in_valid <= 1'b1;
					op <= nxt.op;
					voice <= nxt.vsel;
					word_index <= nxt.widx;
					value <= nxt.val;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct());
		end
	end

endmodule

/* filelist.f */
sv/dsvm_pkg.sv
sv/dsvm_ram.sv
sv/dsvm_mix.sv
sv/drum_sample_voice_mixer_core.sv
tb/sv/tb_drum_sample_voice_mixer_core.sv
